// ===== rtl/ssstk_pkg.sv =====
package ssstk_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_DECLARE = 2'd0,
		OP_LOOKUP  = 2'd1,
		OP_UPDATE  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic [1:0] KIND_SCOPE = 2'd0;

	typedef struct packed {
		logic [7:0]  tail;
		logic [63:0] head;
	} key_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] value;
		logic [7:0]  tail;
		logic [63:0] head;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [PTR_W-1:0] waddr;
		entry_t           wdata;
		logic [PTR_W-1:0] raddr;
	} mem_req_t;

	// A name ends at its first zero character; everything after it is cleared.
	function automatic key_t canon_key(logic [63:0] head, logic [7:0] tail);
		key_t k;
		logic cut;
		cut = 1'b0;
		k.head = head;
		k.tail = tail;
		for (int b = 0; b < 8; b++) begin
			if (head[8*b +: 8] == 8'h00) cut = 1'b1;
			if (cut) k.head[8*b +: 8] = 8'h00;
		end
		if (cut) k.tail = 8'h00;
		return k;
	endfunction

	function automatic logic [7:0] sat_count(logic [CNT_W-1:0] c);
		logic [CNT_W+7:0] w;
		w = (CNT_W + 8)'(c);
		if (w > (CNT_W + 8)'(255)) return 8'hFF;
		return w[7:0];
	endfunction

endpackage

// ===== rtl/ssstk_if.sv =====
interface ssstk_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] name_head;
	logic [7:0]  name_tail;
	logic [31:0] new_value;
	logic [1:0]  entry_kind;

	modport source (output valid, op, name_head, name_tail, new_value, entry_kind,
		input ready);
	modport sink (input valid, op, name_head, name_tail, new_value, entry_kind,
		output ready);
endinterface

interface ssstk_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_value;
	logic [1:0]  status;
	logic [7:0]  entries_held;

	modport source (output valid, read_value, status, entries_held, input ready);
	modport sink (input valid, read_value, status, entries_held, output ready);
endinterface

// ===== rtl/ssstk_store.sv =====
module ssstk_store import ssstk_pkg::*; (
	input  logic     clk,
	input  mem_req_t mem_req,
	output entry_t   rd_data
);

	entry_t mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (mem_req.we) mem[mem_req.waddr] <= mem_req.wdata;
		rd_data <= mem[mem_req.raddr];
	end

endmodule

// ===== rtl/ssstk_ctrl.sv =====
module ssstk_ctrl import ssstk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ssstk_req_if.sink req,
	ssstk_rsp_if.source rsp,
	output mem_req_t  mem_req,
	input  entry_t    rd_data
);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [63:0]       key_head_q;
	logic [7:0]        key_tail_q;
	logic [31:0]       value_q;
	logic [CNT_W-1:0]  top_q;
	logic [PTR_W-1:0]  idx_q;
	logic [31:0]       res_value_q;
	logic [1:0]        res_status_q;
	logic              rsp_valid_q;
	logic [31:0]       rsp_value_q;
	logic [1:0]        rsp_status_q;
	logic [7:0]        rsp_count_q;

	key_t              in_key;
	op_t               in_op;
	logic              accept;
	logic              full;
	logic              empty;
	logic              hit;
	logic              scope;
	logic [CNT_W-1:0]  top_m1;

	assign in_key = canon_key(req.name_head, req.name_tail);
	assign in_op  = op_t'(req.op);
	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign full   = (top_q == CNT_W'(STACK_DEPTH));
	assign empty  = (top_q == '0);
	assign top_m1 = top_q - CNT_W'(1);
	assign hit    = (rd_data.head == key_head_q) && (rd_data.tail == key_tail_q);
	assign scope  = (rd_data.kind == KIND_SCOPE);

	assign rsp.valid        = rsp_valid_q;
	assign rsp.read_value   = rsp_value_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.entries_held = rsp_count_q;

	// The entry one below the one being compared is always fetched, so the
	// walk down the stack examines one entry every cycle.
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = top_q[PTR_W-1:0];
		mem_req.wdata = '{kind: req.entry_kind, value: req.new_value,
			tail: in_key.tail, head: in_key.head};
		mem_req.raddr = (state_q == S_SCAN) ? idx_q - PTR_W'(1) : top_m1[PTR_W-1:0];
		if (accept && in_op == OP_DECLARE && !full) begin
			mem_req.we = 1'b1;
		end else if (state_q == S_SCAN && op_q == OP_UPDATE && hit) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = idx_q;
			mem_req.wdata = '{kind: rd_data.kind, value: value_q,
				tail: rd_data.tail, head: rd_data.head};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_DECLARE;
			key_head_q   <= '0;
			key_tail_q   <= '0;
			value_q      <= '0;
			top_q        <= '0;
			idx_q        <= '0;
			res_value_q  <= '0;
			res_status_q <= ST_DONE;
			rsp_valid_q  <= 1'b0;
			rsp_value_q  <= '0;
			rsp_status_q <= ST_DONE;
			rsp_count_q  <= '0;
		end else begin
			// While emitting, the output register is reloaded below instead.
			if (rsp.ready && state_q != S_EMIT) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q        <= in_op;
						key_head_q  <= in_key.head;
						key_tail_q  <= in_key.tail;
						value_q     <= req.new_value;
						idx_q       <= top_m1[PTR_W-1:0];
						res_value_q <= '0;
						case (in_op)
							OP_DECLARE: begin
								state_q <= S_EMIT;
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									res_status_q <= ST_DONE;
									top_q        <= top_q + CNT_W'(1);
								end
							end
							OP_LOOKUP, OP_UPDATE: begin
								if (empty) begin
									res_status_q <= ST_NOT_FOUND;
									state_q      <= S_EMIT;
								end else begin
									res_status_q <= ST_DONE;
									state_q      <= S_SCAN;
								end
							end
							OP_RELEASE: begin
								res_status_q <= ST_DONE;
								if (empty) state_q <= S_EMIT;
								else state_q <= S_SCAN;
							end
							default: begin
								res_status_q <= ST_DONE;
								state_q      <= S_EMIT;
							end
						endcase
					end
				end
				S_SCAN: begin
					case (op_q)
						OP_LOOKUP, OP_UPDATE: begin
							if (hit) begin
								res_value_q <= (op_q == OP_LOOKUP) ? rd_data.value : value_q;
								state_q     <= S_EMIT;
							end else if (idx_q == '0) begin
								res_status_q <= ST_NOT_FOUND;
								state_q      <= S_EMIT;
							end else begin
								idx_q <= idx_q - PTR_W'(1);
							end
						end
						OP_RELEASE: begin
							// The scope start entry itself is popped as well.
							if (scope) begin
								top_q   <= CNT_W'(idx_q);
								state_q <= S_EMIT;
							end else if (idx_q == '0) begin
								top_q   <= '0;
								state_q <= S_EMIT;
							end else begin
								idx_q <= idx_q - PTR_W'(1);
							end
						end
						default: state_q <= S_EMIT;
					endcase
				end
				S_EMIT: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_value_q  <= res_value_q;
						rsp_status_q <= res_status_q;
						rsp_count_q  <= sat_count(top_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_lookup_keeps_top: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && op_q == OP_LOOKUP) |=> top_q == $past(top_q))
		else $error("lookup changed the stack depth");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && res_status_q == ST_FULL) |-> full)
		else $error("push refused on a stack that is not full");

	a_miss_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q == ST_NOT_FOUND) |-> rsp_value_q == '0)
		else $error("missed name returned a non-zero value");

	a_update_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && op_q == OP_UPDATE && hit) |-> mem_req.we)
		else $error("update hit without a write to the entry store");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("beat accepted but sequencer stayed idle");
`endif

endmodule

// ===== rtl/scoped_symbol_stack_core.sv =====
// Scoped symbol stack: one operation beat in, one result beat out. A declare,
// or any operation that finds the stack empty, goes from acceptance straight to
// the emit state, which loads its result into the output register and returns
// to idle, where the next operation can be taken. Lookup, update and release
// walk the stack from the top, one entry per cycle through the single read
// port of the entry memory, and then pass through the emit state. A new
// operation is taken only once the previous one has handed its result to the
// output register, so a result the receiver has not taken stalls the next one
// in its emit state; no clearing pass is needed after reset.
module scoped_symbol_stack_core import ssstk_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ssstk_req_if.sink   req,
	ssstk_rsp_if.source rsp
);

	mem_req_t mem_req;
	entry_t   rd_data;

	ssstk_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	ssstk_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

endmodule

// ===== sim/ssstk_checker.sv =====
module ssstk_checker import ssstk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ssstk_req_if req,
	ssstk_rsp_if rsp,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   misses,
	output int   refusals,
	output int   deepest
);

	typedef struct packed {
		logic [31:0] value;
		logic [1:0]  status;
		logic [7:0]  held;
	} scope_result_t;

	logic [63:0]   sym_head [STACK_DEPTH];
	logic [7:0]    sym_tail [STACK_DEPTH];
	logic [31:0]   sym_val  [STACK_DEPTH];
	logic [1:0]    sym_kind [STACK_DEPTH];
	int            sym_count;
	scope_result_t result_q [$];

	// Applies one operation to the local copy of the stack and gives its result.
	function automatic scope_result_t stack_step(input op_t op, input logic [63:0] head,
		input logic [7:0] tail, input logic [31:0] val, input logic [1:0] kind);
		scope_result_t r;
		logic [63:0]   h;
		logic [7:0]    t;
		int            name_len;
		int            hit;
		r = '0;
		h = head;
		t = tail;
		// Everything after the first zero character is not part of the name.
		name_len = 8;
		for (int b = 7; b >= 0; b--)
			if (h[8*b +: 8] == 8'h00) name_len = b;
		if (name_len < 8) begin
			h = h & ((64'h1 << (8 * name_len)) - 64'h1);
			t = 8'h00;
		end
		hit = -1;
		for (int i = sym_count - 1; i >= 0; i--)
			if (hit < 0 && sym_head[i] == h && sym_tail[i] == t) hit = i;
		r.status = ST_DONE;
		case (op)
			OP_DECLARE: begin
				if (sym_count >= STACK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					sym_head[sym_count] = h;
					sym_tail[sym_count] = t;
					sym_val[sym_count] = val;
					sym_kind[sym_count] = kind;
					sym_count++;
				end
			end
			OP_LOOKUP: begin
				if (hit < 0) r.status = ST_NOT_FOUND;
				else r.value = sym_val[hit];
			end
			OP_UPDATE: begin
				if (hit < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					sym_val[hit] = val;
					r.value = val;
				end
			end
			OP_RELEASE: begin
				while (sym_count > 0) begin
					sym_count--;
					if (sym_kind[sym_count] == KIND_SCOPE) break;
				end
			end
		endcase
		r.held = (sym_count > 255) ? 8'hFF : 8'(sym_count);
		return r;
	endfunction

	initial begin
		sym_count = 0;
		fail_count = 0;
		pending = 0;
		checked = 0;
		misses = 0;
		refusals = 0;
		deepest = 0;
	end

	always @(posedge clk) begin : watch
		scope_result_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				checked++;
				if (result_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with none outstanding: value %h status %0d held %0d",
							$realtime, rsp.read_value, rsp.status, rsp.entries_held);
				end else begin
					want = result_q.pop_front();
					if (rsp.read_value !== want.value || rsp.status !== want.status ||
						rsp.entries_held !== want.held) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch: expected value %h status %0d held %0d, got value %h status %0d held %0d",
								$realtime, want.value, want.status, want.held,
								rsp.read_value, rsp.status, rsp.entries_held);
					end
				end
			end
			if (req.valid && req.ready) begin
				want = stack_step(op_t'(req.op), req.name_head, req.name_tail, req.new_value,
					req.entry_kind);
				result_q.push_back(want);
				if (want.status == ST_NOT_FOUND) misses++;
				if (want.status == ST_FULL) refusals++;
				if (int'(want.held) > deepest) deepest = want.held;
			end
			pending <= result_q.size();
		end
	end

endmodule

// ===== sim/testbench.sv =====
module testbench;
	import ssstk_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_PER_PHASE = 70;
	localparam logic [1:0] KIND_VAR = 2'd1;
	localparam logic [1:0] KIND_CONST = 2'd2;
	localparam logic [1:0] KIND_FUNC = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	ssstk_req_if req_if ();
	ssstk_rsp_if rsp_if ();

	int fail_count, pending, checked, misses, refusals, deepest;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	logic [63:0] pool_head [16];
	logic [7:0]  pool_tail [16];

	scoped_symbol_stack_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	ssstk_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.rsp        (rsp_if),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.misses     (misses),
		.refusals   (refusals),
		.deepest    (deepest)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void make_name(input int len, output logic [63:0] h, output logic [7:0] t);
		h = '0;
		t = '0;
		for (int b = 0; b < 8; b++)
			if (b < len) h[8*b +: 8] = 8'($urandom_range(255, 1));
		if (len == 9) t = 8'($urandom_range(255, 1));
	endfunction

	// Fills the bytes after the terminating zero with junk, which must not affect matching.
	function automatic void smear_name(inout logic [63:0] h, inout logic [7:0] t);
		int stop;
		stop = 8;
		for (int b = 7; b >= 0; b--)
			if (h[8*b +: 8] == 8'h00) stop = b;
		if (stop < 8) begin
			for (int b = stop + 1; b < 8; b++)
				if ($urandom_range(1) == 1) h[8*b +: 8] = 8'($urandom);
			if ($urandom_range(1) == 1) t = 8'($urandom);
		end
	endfunction

	task automatic pick_name(output logic [63:0] h, output logic [7:0] t);
		int idx;
		if ($urandom_range(99) < 75) begin
			idx = $urandom_range(15);
			h = pool_head[idx];
			t = pool_tail[idx];
			if ($urandom_range(1) == 1) smear_name(h, t);
		end else begin
			h = {32'($urandom), 32'($urandom)};
			t = 8'($urandom);
			if ($urandom_range(99) < 30) h[8*$urandom_range(7) +: 8] = 8'h00;
		end
	endtask

	task automatic send_beat(input op_t op, input logic [63:0] head, input logic [7:0] tail,
		input logic [31:0] val, input logic [1:0] kind);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_if.op <= op;
		req_if.name_head <= head;
		req_if.name_tail <= tail;
		req_if.new_value <= val;
		req_if.entry_kind <= kind;
		req_if.valid <= 1'b1;
		do @(posedge clk); while (!req_if.ready);
		items_sent++;
	endtask

	task automatic random_item();
		logic [63:0] h;
		logic [7:0]  t;
		logic [1:0]  k;
		int          r;
		pick_name(h, t);
		k = ($urandom_range(3) == 0) ? KIND_SCOPE : 2'($urandom_range(3, 1));
		r = $urandom_range(99);
		if (r < 38) send_beat(OP_DECLARE, h, t, 32'($urandom), k);
		else if (r < 68) send_beat(OP_LOOKUP, h, t, 32'($urandom), k);
		else if (r < 85) send_beat(OP_UPDATE, h, t, 32'($urandom), k);
		else send_beat(OP_RELEASE, h, t, 32'($urandom), k);
	endtask

	// Pushes well past the depth so that refused declares are seen, then unwinds.
	task automatic fill_run();
		logic [63:0] h;
		logic [7:0]  t;
		repeat (STACK_DEPTH + 12) begin
			pick_name(h, t);
			send_beat(OP_DECLARE, h, t, 32'($urandom),
				($urandom_range(19) == 0) ? KIND_SCOPE : 2'($urandom_range(3, 1)));
		end
		repeat (6) begin
			pick_name(h, t);
			send_beat(OP_LOOKUP, h, t, 32'($urandom), KIND_VAR);
		end
		repeat (3) begin
			pick_name(h, t);
			send_beat(OP_UPDATE, h, t, 32'($urandom), KIND_VAR);
		end
		repeat (10) begin
			send_beat(OP_RELEASE, 64'h0, 8'h0, 32'h0, KIND_VAR);
			pick_name(h, t);
			send_beat(OP_LOOKUP, h, t, 32'($urandom), KIND_VAR);
		end
	endtask

	// Stops offering beats until every outstanding result has been seen.
	task automatic drain_results();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Output side: random stalls, plus one long hold-off counted here when asked for.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_served) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = OP_DECLARE;
		req_if.name_head = '0;
		req_if.name_tail = '0;
		req_if.new_value = '0;
		req_if.entry_kind = KIND_SCOPE;
		for (int i = 0; i < 16; i++)
			make_name((i == 0) ? 9 : (i == 1) ? 0 : $urandom_range(9, 1),
				pool_head[i], pool_tail[i]);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty stack first, then shadowing, junk after the terminator and scope unwinding.
		send_beat(OP_RELEASE, 64'h0, 8'h00, 32'h0, KIND_SCOPE);
		send_beat(OP_LOOKUP, 64'h61, 8'h00, 32'h0, KIND_VAR);
		send_beat(OP_UPDATE, 64'h61, 8'h00, 32'hFFFF_FFFF, KIND_VAR);
		send_beat(OP_DECLARE, 64'h61, 8'h00, 32'h0, KIND_SCOPE);
		send_beat(OP_DECLARE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, KIND_FUNC);
		send_beat(OP_DECLARE, 64'h0, 8'h5A, 32'h5555_AAAA, KIND_VAR);
		send_beat(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'h0, KIND_VAR);
		send_beat(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFE, 32'h0, KIND_VAR);
		send_beat(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 8'h77, 32'h0, KIND_VAR);
		send_beat(OP_DECLARE, 64'h61, 8'h00, 32'h0000_1234, KIND_CONST);
		send_beat(OP_LOOKUP, 64'hDEAD_BEEF_C0DE_0061, 8'h99, 32'h0, KIND_VAR);
		send_beat(OP_UPDATE, 64'h61, 8'h00, 32'hA5A5_5A5A, KIND_VAR);
		send_beat(OP_UPDATE, 64'h62, 8'h00, 32'h1111_2222, KIND_VAR);
		send_beat(OP_DECLARE, 64'h73, 8'h00, 32'h0, KIND_SCOPE);
		send_beat(OP_DECLARE, 64'h78, 8'h00, 32'h7777_0000, KIND_VAR);
		send_beat(OP_RELEASE, 64'h0, 8'h00, 32'h0, KIND_VAR);
		send_beat(OP_LOOKUP, 64'h61, 8'h00, 32'h0, KIND_VAR);
		send_beat(OP_RELEASE, 64'h0, 8'h00, 32'h0, KIND_VAR);
		send_beat(OP_DECLARE, 64'h70, 8'h00, 32'h0000_0070, KIND_VAR);
		send_beat(OP_DECLARE, 64'h71, 8'h00, 32'h0000_0071, KIND_FUNC);
		send_beat(OP_RELEASE, 64'h0, 8'h00, 32'h0, KIND_VAR);
		send_beat(OP_LOOKUP, 64'h70, 8'h00, 32'h0, KIND_VAR);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 88; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 88; end
				default: begin send_idle_pct = 7; stall_pct = 7; end
			endcase
			if (ph == 0) begin
				// The output holds off while beats keep coming, so the input must back up.
				hold_asked++;
				repeat (12) random_item();
			end
			if (ph == 3) fill_run();
			repeat (RANDOM_PER_PHASE) random_item();
			drain_results();
		end

		repeat (STACK_DEPTH + 8) @(posedge clk);
		$display("%0d operations sent under four handshake patterns, with a full stack and a long output hold-off",
			items_sent);
		$display("%0d results compared: %0d name misses, %0d refused declares, deepest stack %0d",
			checked, misses, refusals, deepest);
		if (pending != 0) $display("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ssstk_pkg.sv
rtl/ssstk_if.sv
rtl/ssstk_store.sv
rtl/ssstk_ctrl.sv
rtl/scoped_symbol_stack_core.sv
sim/ssstk_checker.sv
sim/testbench.sv
